// ----- hdl/tssf_pkg.sv -----
// Shared types, constants and helper functions for the temperature display formatter.
package tssf_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic       REG_DISPLAY_ADDRESS   = 1'b0;
  localparam logic [7:0] DISPLAY_ADDRESS_RESET = 8'hE0;

  localparam logic [11:0] SCALE_FACTOR  = 12'd3150;
  localparam logic [11:0] OFFSET_TENTHS = 12'd490;
  localparam logic [16:0] DIVISOR_ALT   = 17'd65535;
  localparam logic [1:0]  TYPE_ALT      = 2'd1;

  localparam logic [7:0] SEG_F          = 8'h71;
  localparam logic [7:0] SEG_DP         = 8'h80;
  localparam logic [7:0] CMD_DISPLAY_ON = 8'h81;

  localparam logic [7:0] RAM_ADDR_DIGIT0 = 8'h00;
  localparam logic [7:0] RAM_ADDR_DIGIT1 = 8'h02;
  localparam logic [7:0] RAM_ADDR_DIGIT2 = 8'h06;
  localparam logic [7:0] RAM_ADDR_DIGIT3 = 8'h08;

  typedef struct packed {
    logic [7:0] seg3;
    logic [7:0] seg2;
    logic [7:0] seg1;
    logic [7:0] seg0;
  } seg_word_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef enum logic [2:0] {
    SLOT_DIGIT0,
    SLOT_DIGIT1,
    SLOT_DIGIT2,
    SLOT_DIGIT3,
    SLOT_DISPLAY_ON
  } slot_t;

  function automatic logic [7:0] seg_of(input logic [3:0] d);
    logic [7:0] s;
    unique case (d)
      4'd0:    s = 8'h3f;
      4'd1:    s = 8'h06;
      4'd2:    s = 8'h5b;
      4'd3:    s = 8'h4f;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'h6d;
      4'd6:    s = 8'h7d;
      4'd7:    s = 8'h07;
      4'd8:    s = 8'h7f;
      4'd9:    s = 8'h6f;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

  // Digit of v in units of unit, for v below ten units.
  function automatic logic [3:0] digit_of(input logic [9:0] v, input logic [9:0] unit);
    logic [3:0]  d;
    logic [13:0] lim;
    d = '0;
    for (int k = 1; k < 10; k++) begin
      lim = 14'(k) * {4'd0, unit};
      if ({4'd0, v} >= lim) d = 4'(k);
    end
    return d;
  endfunction

endpackage

// ----- hdl/tssf_front.sv -----
// Front pipeline: scale the raw reading, split it into digits, build segment bytes.
module tssf_front
  import tssf_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  logic [1:0]    sensor_type,
  input  logic [15:0]   raw_temperature,
  input  queue_status_t q_stat,
  output logic          q_push,
  output seg_word_t     q_data
);

  logic v1, v2, v3, v4, v5;
  logic en;

  logic [27:0] prod;
  logic        type_alt;
  logic [11:0] tenths;
  logic [3:0]  th3, th4, th5;
  logic [9:0]  r1;
  logic [3:0]  h4;
  logic [6:0]  r2;
  logic        small5;
  seg_word_t   word;

  logic [11:0] quo;
  logic [16:0] rem_sum;
  logic [11:0] scaled;
  logic [11:0] tenths_next;
  logic [3:0]  th_next;
  logic [9:0]  r1_next;
  logic [3:0]  h_next;
  logic [6:0]  r2_next;
  logic [3:0]  te;
  logic [3:0]  ones;
  seg_word_t   word_next;

  assign en     = !(v5 && q_stat.full);
  assign full   = !en;
  assign q_push = v5 && !q_stat.full;
  assign q_data = word;

  always_comb begin
    quo     = prod[27:16];
    rem_sum = {5'd0, quo} + {1'b0, prod[15:0]};
    if (type_alt && rem_sum >= DIVISOR_ALT) begin
      scaled = quo + 12'd1;
    end else begin
      scaled = quo;
    end
    if (scaled >= OFFSET_TENTHS) begin
      tenths_next = scaled - OFFSET_TENTHS;
    end else begin
      tenths_next = '0;
    end
  end

  always_comb begin
    priority if (tenths >= 12'd2000) begin
      th_next = 4'd2;
      r1_next = 10'(tenths - 12'd2000);
    end else if (tenths >= 12'd1000) begin
      th_next = 4'd1;
      r1_next = 10'(tenths - 12'd1000);
    end else begin
      th_next = 4'd0;
      r1_next = 10'(tenths);
    end
  end

  always_comb begin
    h_next  = digit_of(r1, 10'd100);
    r2_next = 7'(r1 - ({6'd0, h_next} * 10'd100));
  end

  always_comb begin
    te   = digit_of({3'd0, r2}, 10'd10);
    ones = 4'(r2 - ({3'd0, te} * 7'd10));
    if (th4 == 4'd0) begin
      word_next.seg0 = seg_of(h4);
      word_next.seg1 = seg_of(te) | SEG_DP;
      word_next.seg2 = seg_of(ones);
      word_next.seg3 = SEG_F;
    end else begin
      word_next.seg0 = seg_of(th4);
      word_next.seg1 = seg_of(h4);
      word_next.seg2 = seg_of(te) | SEG_DP;
      word_next.seg3 = seg_of(ones);
    end
  end

  assign small5 = (th5 == 4'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (en) begin
      v1 <= push;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod     <= {12'd0, raw_temperature} * {16'd0, SCALE_FACTOR};
      type_alt <= (sensor_type == TYPE_ALT);
      tenths   <= tenths_next;
      th3      <= th_next;
      r1       <= r1_next;
      th4      <= th3;
      h4       <= h_next;
      r2       <= r2_next;
      th5      <= th4;
      word     <= word_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (v5 && q_stat.full) |=> (v5 && $stable(word)))
    else $error("front: stalled segment word changed");

  assert property (@(posedge clk) disable iff (rst)
    (v5 && small5) |-> (word.seg3 == SEG_F))
    else $error("front: F glyph missing below one hundred degrees");

endmodule

// ----- hdl/tssf_queue.sv -----
// Short queue of segment words between the front pipeline and the result sequencer.
module tssf_queue
  import tssf_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  seg_word_t     wr_data,
  input  logic          pop,
  output seg_word_t     rd_data,
  output queue_status_t stat
);

  seg_word_t         mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign stat.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign stat.empty = (count == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rd_data    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (do_pop) rd_ptr <= rd_ptr + QPTR_W'(1);
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) push |-> !stat.full)
    else $error("queue: request pushed while full");

  assert property (@(posedge clk) disable iff (rst) (push && !pop) |=> !stat.empty)
    else $error("queue: empty after a push");

endmodule

// ----- hdl/tssf_back.sv -----
// Result sequencer: four digit writes then the display-on command per reading.
module tssf_back
  import tssf_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic [7:0]    display_address,
  input  queue_status_t q_stat,
  input  seg_word_t     q_data,
  output logic          q_pop,
  output logic          empty,
  input  logic          pop,
  output logic [7:0]    device_address,
  output logic          is_command,
  output logic [7:0]    command_byte,
  output logic [7:0]    segment_data,
  output logic          last
);

  slot_t     slot, slot_next;
  logic      out_valid, out_valid_next;
  seg_word_t word;
  logic      advance;
  logic      more;

  assign advance = !out_valid || pop;
  assign more    = out_valid && (slot != SLOT_DISPLAY_ON);
  assign empty   = !out_valid;

  always_comb begin
    slot_next      = slot;
    out_valid_next = out_valid;
    q_pop          = 1'b0;
    if (advance) begin
      if (more) begin
        unique case (slot)
          SLOT_DIGIT0: slot_next = SLOT_DIGIT1;
          SLOT_DIGIT1: slot_next = SLOT_DIGIT2;
          SLOT_DIGIT2: slot_next = SLOT_DIGIT3;
          default:     slot_next = SLOT_DISPLAY_ON;
        endcase
      end else if (!q_stat.empty) begin
        slot_next      = SLOT_DIGIT0;
        out_valid_next = 1'b1;
        q_pop          = 1'b1;
      end else begin
        out_valid_next = 1'b0;
      end
    end
  end

  always_comb begin
    device_address = display_address;
    is_command     = 1'b0;
    last           = 1'b0;
    unique case (slot)
      SLOT_DIGIT0: begin
        command_byte = RAM_ADDR_DIGIT0;
        segment_data = word.seg0;
      end
      SLOT_DIGIT1: begin
        command_byte = RAM_ADDR_DIGIT1;
        segment_data = word.seg1;
      end
      SLOT_DIGIT2: begin
        command_byte = RAM_ADDR_DIGIT2;
        segment_data = word.seg2;
      end
      SLOT_DIGIT3: begin
        command_byte = RAM_ADDR_DIGIT3;
        segment_data = word.seg3;
      end
      default: begin
        is_command   = 1'b1;
        last         = 1'b1;
        command_byte = CMD_DISPLAY_ON;
        segment_data = 8'h00;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot      <= SLOT_DIGIT0;
      out_valid <= 1'b0;
    end else begin
      slot      <= slot_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      word <= q_data;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && pop && slot == SLOT_DIGIT3) |=> (out_valid && slot == SLOT_DISPLAY_ON))
    else $error("back: display-on command skipped");

  assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (!out_valid || (pop && slot == SLOT_DISPLAY_ON)))
    else $error("back: new reading taken before the run ended");

endmodule

// ----- hdl/temperature_seven_segment_formatter.sv -----
// Top level of the temperature display formatter: register port, front, queue and sequencer.
// Each accepted reading yields five results (digit writes to RAM addresses 0, 2, 6, 8, then
// the display-on command), one per cycle while pop is held, so in steady state the result
// sequencer, not the front, sets how often a new reading is taken. A reading passes through
// a five-stage arithmetic pipeline (multiply, divide and offset, thousands, hundreds, then
// tens and segment build) and a four-entry queue, so the first result of a reading appears
// only after it has passed the pipeline registers, the queue and the sequencer's word
// register. display_address sits at byte address 0 and is copied into every result.
module temperature_seven_segment_formatter
  import tssf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         sensor_type,
  input  logic [15:0]        raw_temperature,
  output logic               empty,
  input  logic               pop,
  output logic [7:0]         device_address,
  output logic               is_command,
  output logic [7:0]         command_byte,
  output logic [7:0]         segment_data,
  output logic               last
);

  logic [7:0]    display_address;
  logic          reg_sel;
  queue_status_t q_stat;
  logic          q_push;
  logic          q_pop;
  seg_word_t     q_wr_data;
  seg_word_t     q_rd_data;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[PADDR_W-1] == REG_DISPLAY_ADDRESS);
  assign prdata  = reg_sel ? {{(PDATA_W - 8){1'b0}}, display_address} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      display_address <= DISPLAY_ADDRESS_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      display_address <= pwdata[7:0];
    end
  end

  tssf_front u_front (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .sensor_type     (sensor_type),
    .raw_temperature (raw_temperature),
    .q_stat          (q_stat),
    .q_push          (q_push),
    .q_data          (q_wr_data)
  );

  tssf_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (q_wr_data),
    .pop     (q_pop),
    .rd_data (q_rd_data),
    .stat    (q_stat)
  );

  tssf_back u_back (
    .clk             (clk),
    .rst             (rst),
    .display_address (display_address),
    .q_stat          (q_stat),
    .q_data          (q_rd_data),
    .q_pop           (q_pop),
    .empty           (empty),
    .pop             (pop),
    .device_address  (device_address),
    .is_command      (is_command),
    .command_byte    (command_byte),
    .segment_data    (segment_data),
    .last            (last)
  );

endmodule
